### hw/rtl/wavhp_pkg.sv
// Package for the WAV header parser: stream widths, chunk tags and status codes.
// No dependencies; imported by wav_header_parser_core and its testbench.
package wavhp_pkg;

    // Stream widths
    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 136;

    // Field widths
    localparam int STATUS_W = 3;
    localparam int CHAN_W   = 16;
    localparam int RATE_W   = 32;
    localparam int DEPTH_W  = 16;
    localparam int SIZE_W   = 32;
    localparam int POS_W    = 32;
    localparam int CNT_W    = 3;
    localparam int PAD_W    = M_TDATA_W - STATUS_W - CHAN_W - RATE_W - DEPTH_W
                              - SIZE_W - POS_W;

    // Chunk tags, first byte in the high lane
    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    // Format tag 1 (PCM) as seen in the low half of the window: 01 then 00
    localparam logic [15:0] FMT_PCM_WIN = 16'h0100;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_PARSING = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DONE    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_RIFF = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_WAVE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NO_FMT  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NOT_PCM = 3'd5;
    localparam logic [STATUS_W-1:0] ST_NO_DATA = 3'd6;

endpackage

### hw/rtl/wav_header_parser_core.sv
// Byte-serial RIFF/WAVE PCM header parser, top level.
// Depends on wavhp_pkg (widths, tags, status codes).
// An accepted byte goes through the input stage, then the state/result stage, before its result is offered on m_*.
// Throughput: one byte per cycle; a stalled output holds both the input stage and the state.
// Reset: synchronous active-low aresetn clears the pipeline valids and all parser state.
// s_tuser restarts parsing (state cleared before that byte is parsed).
module wav_header_parser_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    // s_tdata: [7:0] file_byte
    input  logic [wavhp_pkg::S_TDATA_W-1:0] s_tdata,
    // s_tuser: [0] first_byte
    input  logic [wavhp_pkg::S_TUSER_W-1:0] s_tuser,
    input  logic                            s_tlast,   // final_byte
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // m_tdata: [2:0] status, [18:3] channel_count, [50:19] rate_hz,
    //          [66:51] bits_per_sample, [98:67] payload_size,
    //          [130:99] payload_offset, [135:131] zero
    output logic [wavhp_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready
);
    import wavhp_pkg::*;

    // Parser phases, in file order
    typedef enum logic [3:0] {
        PH_RIFF_TAG    = 4'd0,
        PH_RIFF_SIZE   = 4'd1,
        PH_WAVE_TAG    = 4'd2,
        PH_FMT_SEARCH  = 4'd3,
        PH_FMT_SIZE    = 4'd4,
        PH_FMT_TAG     = 4'd5,
        PH_CHANNELS    = 4'd6,
        PH_RATE        = 4'd7,
        PH_BYTE_RATE   = 4'd8,
        PH_ALIGN       = 4'd9,
        PH_DEPTH       = 4'd10,
        PH_DATA_SEARCH = 4'd11,
        PH_DATA_SIZE   = 4'd12,
        PH_HOLD        = 4'd13
    } phase_t;

    // Input stage
    logic                 in_valid_reg;
    logic [7:0]           in_byte_reg;
    logic                 in_first_reg;
    logic                 in_last_reg;

    // Parser state; the field and status registers double as the result register
    phase_t               phase_reg, phase_next;
    logic [31:0]          win_reg, win_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic [CHAN_W-1:0]    chan_reg, chan_next;
    logic [RATE_W-1:0]    rate_reg, rate_next;
    logic [DEPTH_W-1:0]   depth_reg, depth_next;
    logic [SIZE_W-1:0]    psize_reg, psize_next;
    logic [POS_W-1:0]     poff_reg, poff_next;
    logic                 out_valid_reg;

    // Starting point for this byte (cleared when the byte opens a new file)
    phase_t               cur_phase;
    logic [31:0]          cur_win;
    logic [CNT_W-1:0]     cur_cnt;
    logic [POS_W-1:0]     cur_pos;
    logic [STATUS_W-1:0]  cur_status;
    logic [CHAN_W-1:0]    cur_chan;
    logic [RATE_W-1:0]    cur_rate;
    logic [DEPTH_W-1:0]   cur_depth;
    logic [SIZE_W-1:0]    cur_psize;
    logic [POS_W-1:0]     cur_poff;
    logic [1:0]           lane;

    logic                 advance;

    // Move the input stage into the state/result stage when the output is free
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, poff_reg, psize_reg, depth_reg, rate_reg,
                       chan_reg, status_reg};

    always_comb begin
        cur_phase  = in_first_reg ? PH_RIFF_TAG : phase_reg;
        cur_win    = in_first_reg ? '0 : win_reg;
        cur_cnt    = in_first_reg ? '0 : cnt_reg;
        cur_pos    = in_first_reg ? '0 : pos_reg;
        cur_status = in_first_reg ? ST_PARSING : status_reg;
        cur_chan   = in_first_reg ? '0 : chan_reg;
        cur_rate   = in_first_reg ? '0 : rate_reg;
        cur_depth  = in_first_reg ? '0 : depth_reg;
        cur_psize  = in_first_reg ? '0 : psize_reg;
        cur_poff   = in_first_reg ? '0 : poff_reg;

        phase_next  = cur_phase;
        win_next    = cur_win;
        cnt_next    = cur_cnt;
        pos_next    = cur_pos;
        status_next = cur_status;
        chan_next   = cur_chan;
        rate_next   = cur_rate;
        depth_next  = cur_depth;
        psize_next  = cur_psize;
        poff_next   = cur_poff;
        lane        = 2'd0;

        if (cur_phase < PH_HOLD) begin
            pos_next = cur_pos + 32'd1;
            win_next = {cur_win[23:0], in_byte_reg};
            // Byte count saturates at four: enough for every match and capture
            cnt_next = (cur_cnt < 3'd4) ? 3'(cur_cnt + 3'd1) : cur_cnt;
            // Little-endian byte lane of the field being captured
            lane     = 2'(cnt_next - 3'd1);

            unique case (cur_phase)
                PH_RIFF_TAG: begin
                    if (cnt_next == 3'd4) begin
                        if (win_next == TAG_RIFF) begin
                            phase_next = PH_RIFF_SIZE;
                            cnt_next   = '0;
                        end else begin
                            phase_next  = PH_HOLD;
                            status_next = ST_NO_RIFF;
                        end
                    end
                end
                PH_WAVE_TAG: begin
                    if (cnt_next == 3'd4) begin
                        if (win_next == TAG_WAVE) begin
                            phase_next = PH_FMT_SEARCH;
                            cnt_next   = '0;
                        end else begin
                            phase_next  = PH_HOLD;
                            status_next = ST_NO_WAVE;
                        end
                    end
                end
                PH_FMT_SEARCH: begin
                    if (cnt_next == 3'd4 && win_next == TAG_FMT) begin
                        phase_next = PH_FMT_SIZE;
                        cnt_next   = '0;
                    end
                end
                PH_FMT_TAG: begin
                    if (cnt_next == 3'd2) begin
                        if (win_next[15:0] == FMT_PCM_WIN) begin
                            phase_next = PH_CHANNELS;
                            cnt_next   = '0;
                        end else begin
                            phase_next  = PH_HOLD;
                            status_next = ST_NOT_PCM;
                        end
                    end
                end
                PH_CHANNELS: begin
                    chan_next = cur_chan | (16'(in_byte_reg) << {lane[0], 3'b000});
                    if (cnt_next == 3'd2) begin
                        phase_next = PH_RATE;
                        cnt_next   = '0;
                    end
                end
                PH_RATE: begin
                    rate_next = cur_rate | (32'(in_byte_reg) << {lane, 3'b000});
                    if (cnt_next == 3'd4) begin
                        phase_next = PH_BYTE_RATE;
                        cnt_next   = '0;
                    end
                end
                PH_ALIGN: begin
                    if (cnt_next == 3'd2) begin
                        phase_next = PH_DEPTH;
                        cnt_next   = '0;
                    end
                end
                PH_DEPTH: begin
                    depth_next = cur_depth | (16'(in_byte_reg) << {lane[0], 3'b000});
                    if (cnt_next == 3'd2) begin
                        phase_next = PH_DATA_SEARCH;
                        cnt_next   = '0;
                    end
                end
                PH_DATA_SEARCH: begin
                    if (cnt_next == 3'd4 && win_next == TAG_DATA) begin
                        phase_next = PH_DATA_SIZE;
                        cnt_next   = '0;
                    end
                end
                PH_DATA_SIZE: begin
                    psize_next = cur_psize | (32'(in_byte_reg) << {lane, 3'b000});
                    if (cnt_next == 3'd4) begin
                        // Samples start at the byte after the size field
                        poff_next   = pos_next;
                        status_next = ST_DONE;
                        phase_next  = PH_HOLD;
                    end
                end
                default: begin
                    // RIFF size, fmt chunk size and byte rate: skip four bytes
                    if (cnt_next == 3'd4) begin
                        phase_next = phase_t'(cur_phase + 4'd1);
                        cnt_next   = '0;
                    end
                end
            endcase

            // End of stream with the header unfinished: fail on the pending phase
            if (in_last_reg && phase_next < PH_HOLD) begin
                unique case (phase_next) inside
                    PH_RIFF_TAG:                 status_next = ST_NO_RIFF;
                    PH_RIFF_SIZE, PH_WAVE_TAG:   status_next = ST_NO_WAVE;
                    PH_FMT_SEARCH:               status_next = ST_NO_FMT;
                    PH_FMT_SIZE, PH_FMT_TAG:     status_next = ST_NOT_PCM;
                    default:                     status_next = ST_NO_DATA;
                endcase
                phase_next = PH_HOLD;
            end
        end
    end

    // Input stage payload needs no reset
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg  <= s_tdata[7:0];
            in_first_reg <= s_tuser[0];
            in_last_reg  <= s_tlast;
        end
    end

    // Parser state and registered result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_RIFF_TAG;
            win_reg       <= '0;
            cnt_reg       <= '0;
            pos_reg       <= '0;
            status_reg    <= ST_PARSING;
            chan_reg      <= '0;
            rate_reg      <= '0;
            depth_reg     <= '0;
            psize_reg     <= '0;
            poff_reg      <= '0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                phase_reg     <= phase_next;
                win_reg       <= win_next;
                cnt_reg       <= cnt_next;
                pos_reg       <= pos_next;
                status_reg    <= status_next;
                chan_reg      <= chan_next;
                rate_reg      <= rate_next;
                depth_reg     <= depth_next;
                psize_reg     <= psize_next;
                poff_reg      <= poff_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    // A final status is only ever held in the hold phase
    a_status_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (status_reg != ST_PARSING) |-> (phase_reg == PH_HOLD))
        else $error("final status outside hold phase");

    // Phase byte count saturates at four
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg <= 3'd4))
        else $error("phase byte count out of range");

    // Bytes after done or failure do not move the file position
    a_hold_position: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && phase_reg == PH_HOLD && !in_first_reg) |=> $stable(pos_reg))
        else $error("file position moved in hold phase");

    // A result only appears for a byte that left the input stage
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        ($rose(out_valid_reg)) |-> $past(in_valid_reg))
        else $error("result without input byte");
`endif

endmodule

### verif/wav_header_parser_core_test.sv
// Self-checking testbench for wav_header_parser_core: directed table, then random WAV files.
// Depends on wavhp_pkg and wav_header_parser_core; a built-in header parser predicts the results.
`timescale 1ns / 1ps

module wav_header_parser_core_test;
    import wavhp_pkg::*;

    // ------------------------------------------------------------------
    // Clock, reset, DUT ports
    // ------------------------------------------------------------------
    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata  = '0;   // [7:0] file_byte
    logic [S_TUSER_W-1:0] s_tuser  = '0;   // [0] first_byte
    logic                 s_tlast  = 1'b0; // final_byte
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [M_TDATA_W-1:0] m_tdata;         // status, channels, rate, depth, size, offset, pad
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;

    always #5 aclk = ~aclk;

    wav_header_parser_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    // ------------------------------------------------------------------
    // Result layout: declared MSB first so m_tdata casts straight onto it
    // ------------------------------------------------------------------
    typedef struct packed {
        logic [PAD_W-1:0]    pad;
        logic [POS_W-1:0]    offset;
        logic [SIZE_W-1:0]   size;
        logic [DEPTH_W-1:0]  depth;
        logic [RATE_W-1:0]   rate;
        logic [CHAN_W-1:0]   chans;
        logic [STATUS_W-1:0] status;
    } hdr_t;

    // Parser phases, in header order
    typedef enum logic [3:0] {
        PH_RIFF_TAG, PH_RIFF_SIZE, PH_WAVE_TAG, PH_FMT_SEEK, PH_FMT_SIZE,
        PH_FMT_TAG, PH_CHANNELS, PH_RATE, PH_BYTE_RATE, PH_ALIGN, PH_DEPTH,
        PH_DATA_SEEK, PH_DATA_SIZE, PH_HOLD
    } phase_t;

    // ------------------------------------------------------------------
    // Header parser predictor
    // ------------------------------------------------------------------
    phase_t      ph       = PH_RIFF_TAG;
    logic [31:0] ph_win   = '0;   // last four bytes, newest in the low lane
    logic [2:0]  ph_cnt   = '0;   // bytes seen in the current phase, saturates at 4
    logic [31:0] byte_pos = '0;
    hdr_t        held     = '0;

    function automatic void parser_clear();
        ph       = PH_RIFF_TAG;
        ph_win   = '0;
        ph_cnt   = '0;
        byte_pos = '0;
        held     = '0;
    endfunction

    function automatic void next_phase();
        ph     = phase_t'(ph + 4'd1);
        ph_cnt = '0;
    endfunction

    function automatic void stop_with(logic [STATUS_W-1:0] code);
        held.status = code;
        ph          = PH_HOLD;
    endfunction

    function automatic hdr_t parse_byte(logic [7:0] b, logic is_first, logic is_last);
        logic [4:0] sh;
        if (is_first)
            parser_clear();
        if (ph != PH_HOLD) begin
            byte_pos = byte_pos + 32'd1;
            ph_win   = {ph_win[23:0], b};
            if (ph_cnt < 3'd4)
                ph_cnt = ph_cnt + 3'd1;
            // little-endian lane of the byte inside the field being captured
            sh = {2'(ph_cnt - 3'd1), 3'b000};
            case (ph)
                PH_RIFF_TAG: begin
                    if (ph_cnt == 3'd4) begin
                        if (ph_win == TAG_RIFF) next_phase(); else stop_with(ST_NO_RIFF);
                    end
                end
                PH_WAVE_TAG: begin
                    if (ph_cnt == 3'd4) begin
                        if (ph_win == TAG_WAVE) next_phase(); else stop_with(ST_NO_WAVE);
                    end
                end
                PH_FMT_SEEK: begin
                    if (ph_cnt == 3'd4 && ph_win == TAG_FMT) next_phase();
                end
                PH_FMT_TAG: begin
                    if (ph_cnt == 3'd2) begin
                        if (ph_win[15:0] == FMT_PCM_WIN) next_phase(); else stop_with(ST_NOT_PCM);
                    end
                end
                PH_CHANNELS: begin
                    held.chans = held.chans | (16'(b) << sh);
                    if (ph_cnt == 3'd2) next_phase();
                end
                PH_RATE: begin
                    held.rate = held.rate | (32'(b) << sh);
                    if (ph_cnt == 3'd4) next_phase();
                end
                PH_ALIGN: begin
                    if (ph_cnt == 3'd2) next_phase();
                end
                PH_DEPTH: begin
                    held.depth = held.depth | (16'(b) << sh);
                    if (ph_cnt == 3'd2) next_phase();
                end
                PH_DATA_SEEK: begin
                    if (ph_cnt == 3'd4 && ph_win == TAG_DATA) next_phase();
                end
                PH_DATA_SIZE: begin
                    held.size = held.size | (32'(b) << sh);
                    if (ph_cnt == 3'd4) begin
                        held.offset = byte_pos;
                        stop_with(ST_DONE);
                    end
                end
                default: begin  // riff size, fmt size, byte rate: skip four
                    if (ph_cnt == 3'd4) next_phase();
                end
            endcase
            // end of stream before the header finished
            if (is_last && ph != PH_HOLD) begin
                case (ph) inside
                    PH_RIFF_TAG:               stop_with(ST_NO_RIFF);
                    PH_RIFF_SIZE, PH_WAVE_TAG: stop_with(ST_NO_WAVE);
                    PH_FMT_SEEK:               stop_with(ST_NO_FMT);
                    PH_FMT_SIZE, PH_FMT_TAG:   stop_with(ST_NOT_PCM);
                    default:                   stop_with(ST_NO_DATA);
                endcase
            end
        end
        return held;
    endfunction

    // ------------------------------------------------------------------
    // Pending headers and checking
    // ------------------------------------------------------------------
    hdr_t pending_headers [$];
    int   headers_checked = 0;
    int   mismatches      = 0;
    int   bytes_sent      = 0;

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("MISMATCH %s", msg);
    endtask

    function automatic string fmt_hdr(hdr_t h);
        return $sformatf("st=%0d ch=%0d rate=%0d bits=%0d size=%0d off=%0d pad=%0h",
                         h.status, h.chans, h.rate, h.depth, h.size, h.offset, h.pad);
    endfunction

    task automatic check_header(input hdr_t got);
        hdr_t  want;
        string diffs;
        diffs = "";
        if (pending_headers.size() == 0) begin
            report_mismatch($sformatf("result transfer with nothing pending: %s", fmt_hdr(got)));
            return;
        end
        want = pending_headers.pop_front();
        if (got.status !== want.status) diffs = {diffs, " status"};
        if (got.chans  !== want.chans)  diffs = {diffs, " channel_count"};
        if (got.rate   !== want.rate)   diffs = {diffs, " rate_hz"};
        if (got.depth  !== want.depth)  diffs = {diffs, " bits_per_sample"};
        if (got.size   !== want.size)   diffs = {diffs, " payload_size"};
        if (got.offset !== want.offset) diffs = {diffs, " payload_offset"};
        if (got.pad    !== want.pad)    diffs = {diffs, " pad"};
        if (diffs != "")
            report_mismatch($sformatf("result %0d, fields:%s\n  want %s\n  got  %s",
                                      headers_checked, diffs, fmt_hdr(want), fmt_hdr(got)));
        headers_checked++;
    endtask

    // Sampled in the active region right after the edge: pre-edge values.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            check_header(hdr_t'(m_tdata));
    end

    // ------------------------------------------------------------------
    // Receiver: rotating ready pattern, reloaded when the cycle counter wraps.
    // Bit 0 forced high, so a loaded pattern is never all stalls.
    // ------------------------------------------------------------------
    logic [15:0] rdy_pat = 16'hFFFF;
    logic [5:0]  rdy_cyc = '0;

    always @(posedge aclk) begin
        if (rdy_cyc == 6'd0)
            rdy_pat = ($urandom_range(0, 2) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
        rdy_pat  = {rdy_pat[14:0], rdy_pat[15]};
        rdy_cyc  = (rdy_cyc == 6'd47) ? 6'd0 : rdy_cyc + 6'd1;
        m_tready <= rdy_pat[0];
    end

    // ------------------------------------------------------------------
    // Sender: bursts of random length, random gaps between them
    // ------------------------------------------------------------------
    int burst_left = 0;

    // typed: the row's status is taken from the table instead of the predictor
    task automatic send_byte(input logic [7:0] b, input logic is_first, input logic is_last,
                             input logic typed, input logic [STATUS_W-1:0] st);
        hdr_t want;
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 16);
        end
        s_tdata  <= b;
        s_tuser  <= is_first;
        s_tlast  <= is_last;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        // transfer taken at this edge
        want = parse_byte(b, is_first, is_last);
        if (typed)
            want.status = st;
        pending_headers.push_back(want);
        burst_left--;
        bytes_sent++;
    endtask

    // ------------------------------------------------------------------
    // Directed table: byte, first, final, status typed?, status
    // ------------------------------------------------------------------
    typedef struct packed {
        logic [7:0]          b;
        logic                is_first;
        logic                is_last;
        logic                typed;
        logic [STATUS_W-1:0] st;
    } row_t;

    localparam row_t DIR_ROWS [23] = '{
        // stream ends on its first byte, straight out of reset
        '{8'hFF, 1'b0, 1'b1, 1'b1, ST_NO_RIFF},
        // restart, wrong fourth tag byte
        '{"R",   1'b1, 1'b0, 1'b1, ST_PARSING},
        '{"I",   1'b0, 1'b0, 1'b0, ST_PARSING},
        '{"F",   1'b0, 1'b0, 1'b0, ST_PARSING},
        '{"X",   1'b0, 1'b0, 1'b1, ST_NO_RIFF},
        // held after a failure: byte ignored even when flagged final
        '{8'h00, 1'b0, 1'b1, 1'b1, ST_NO_RIFF},
        // tag completed by the final byte: size still pending
        '{"R",   1'b1, 1'b0, 1'b1, ST_PARSING},
        '{"I",   1'b0, 1'b0, 1'b0, ST_PARSING},
        '{"F",   1'b0, 1'b0, 1'b0, ST_PARSING},
        '{"F",   1'b0, 1'b1, 1'b1, ST_NO_WAVE},
        // size byte extremes, then a bad WAVE tag
        '{"R",   1'b1, 1'b0, 1'b0, ST_PARSING},
        '{"I",   1'b0, 1'b0, 1'b0, ST_PARSING},
        '{"F",   1'b0, 1'b0, 1'b0, ST_PARSING},
        '{"F",   1'b0, 1'b0, 1'b0, ST_PARSING},
        '{8'h00, 1'b0, 1'b0, 1'b0, ST_PARSING},
        '{8'hFF, 1'b0, 1'b0, 1'b0, ST_PARSING},
        '{8'h80, 1'b0, 1'b0, 1'b0, ST_PARSING},
        '{8'h7F, 1'b0, 1'b0, 1'b0, ST_PARSING},
        '{"W",   1'b0, 1'b0, 1'b0, ST_PARSING},
        '{"A",   1'b0, 1'b0, 1'b0, ST_PARSING},
        '{"V",   1'b0, 1'b0, 1'b0, ST_PARSING},
        '{"Y",   1'b0, 1'b0, 1'b1, ST_NO_WAVE},
        // first and final on the same byte
        '{8'h00, 1'b1, 1'b1, 1'b1, ST_NO_RIFF}
    };

    // ------------------------------------------------------------------
    // Random WAV file builder
    // ------------------------------------------------------------------
    logic [7:0] file_q [$];
    int         fmt_tag_end;   // byte count through the "fmt " tag
    int         data_tag_end;  // byte count through the "data" tag

    function automatic void put_tag(logic [31:0] tag);
        for (int i = 3; i >= 0; i--)
            file_q.push_back(tag[8*i +: 8]);
    endfunction

    function automatic void put_le(logic [31:0] v, int n);
        for (int i = 0; i < n; i++)
            file_q.push_back(v[8*i +: 8]);
    endfunction

    function automatic logic [31:0] pick_val();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // filler ahead of a searched tag, often made of the tag's own letters
    function automatic void put_junk(logic [31:0] tag, int n);
        for (int i = 0; i < n; i++)
            file_q.push_back($urandom_range(0, 1) ? 8'($urandom)
                                                  : tag[8*$urandom_range(0, 3) +: 8]);
    endfunction

    function automatic void build_file();
        int kind;
        kind = $urandom_range(0, 9);
        file_q.delete();
        fmt_tag_end  = 0;
        data_tag_end = 0;
        if (kind == 0) begin
            // noise, sometimes behind a damaged RIFF tag
            if ($urandom_range(0, 1))
                put_tag(TAG_RIFF ^ (32'h1 << $urandom_range(0, 31)));
            repeat ($urandom_range(1, 10)) file_q.push_back(8'($urandom));
            fmt_tag_end  = file_q.size();
            data_tag_end = file_q.size();
            return;
        end
        put_tag(TAG_RIFF);
        put_le(pick_val(), 4);
        put_tag(kind == 1 ? TAG_WAVE ^ (32'h1 << $urandom_range(0, 31)) : TAG_WAVE);
        put_junk(TAG_FMT, $urandom_range(0, 5));
        put_tag(TAG_FMT);
        fmt_tag_end = file_q.size();
        put_le(pick_val(), 4);
        // format tag 1, or one bit off it
        put_le(kind == 2 ? 32'h0001 ^ (32'h1 << $urandom_range(0, 15)) : 32'h0001, 2);
        put_le(pick_val(), 2);   // channels
        put_le(pick_val(), 4);   // sample rate
        put_le(pick_val(), 4);   // byte rate
        put_le(pick_val(), 2);   // block align
        put_le(pick_val(), 2);   // bits per sample
        put_junk(TAG_DATA, $urandom_range(0, 8));
        put_tag(TAG_DATA);
        data_tag_end = file_q.size();
        put_le(pick_val(), 4);
        repeat ($urandom_range(0, 3)) file_q.push_back(8'($urandom));
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        int   cut;
        int   files;
        int   rand_bytes;
        logic mark_first;
        logic mark_last;

        files      = 0;
        rand_bytes = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (DIR_ROWS[i])
            send_byte(DIR_ROWS[i].b, DIR_ROWS[i].is_first, DIR_ROWS[i].is_last,
                      DIR_ROWS[i].typed, DIR_ROWS[i].st);

        while (rand_bytes < 900) begin
            // every sixth file starts only once all results are back
            if (files % 6 == 2) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
                while (pending_headers.size() != 0) @(posedge aclk);
            end
            build_file();
            case ($urandom_range(0, 7))
                0:       cut = $urandom_range(1, file_q.size());
                1:       cut = fmt_tag_end;   // search ends on its match
                2:       cut = data_tag_end;
                default: cut = file_q.size();
            endcase
            mark_first = ($urandom_range(0, 9) != 0);
            mark_last  = ($urandom_range(0, 9) != 0);
            for (int i = 0; i < cut; i++)
                send_byte(file_q[i], (i == 0) && mark_first, (i == cut - 1) && mark_last,
                          1'b0, ST_PARSING);
            rand_bytes += cut;
            files++;
        end

        // drain the pending results, then idle before finishing
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_headers.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog: fires far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
